@@ rtl/core/zoh_sinc_compensation_fir_assert.svh @@
// ----------------------------------------------------------------------------
// ZOH sinc compensation FIR assertion macros
// Short forms for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef ZOH_SINC_COMPENSATION_FIR_ASSERT_SVH
`define ZOH_SINC_COMPENSATION_FIR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ZSC_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("zoh_sinc_compensation_fir: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ZSC_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("zoh_sinc_compensation_fir: next-cycle check failed");

`endif

@@ rtl/core/zsc_fir_pkg.sv @@
// ----------------------------------------------------------------------------
// ZOH sinc compensation FIR package
// Payload types, fixed sizes, coefficient table and controller commands.
// ----------------------------------------------------------------------------
package zsc_fir_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int TAP_COUNT   = 33;
    localparam int HALF_TAPS   = TAP_COUNT / 2;
    localparam int TABLE_SHIFT = 32;
    localparam int TAP_IDX_W   = $clog2(TAP_COUNT);
    localparam int PAIR_IDX_W  = $clog2(HALF_TAPS + 1);

    // Coefficients scaled by 2^32; the last entry is the centre tap.
    localparam longint COEF_Q32 [HALF_TAPS + 1] = '{
        64'sd266977,     -64'sd549624,    64'sd1115726,    -64'sd1489526,
        64'sd2170988,    -64'sd2770282,   64'sd3716935,    -64'sd4818304,
        64'sd6375306,    -64'sd8651231,   64'sd11888754,   -64'sd17701865,
        64'sd27094617,   -64'sd48852554,  64'sd100898524,  -64'sd335458751,
        64'sd4826519059
    };

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_in;
        logic                          block_last_in;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic                          block_last_out;
    } t_out_item;

    typedef struct packed {
        logic                  load;
        logic                  rd;
        logic                  center;
        logic [PAIR_IDX_W-1:0] idx;
        logic                  finish;
    } t_dp_cmd;

    // Reduces a table entry to frac_bits fractional bits, rounding half away from zero.
    function automatic longint coef_round(input logic [PAIR_IDX_W-1:0] idx,
                                          input int frac_bits);
        longint          v;
        longint unsigned mag;
        int              sh;
        v   = (idx > PAIR_IDX_W'(HALF_TAPS)) ? 64'sd0 : COEF_Q32[idx];
        mag = (v < 0) ? $unsigned(-v) : $unsigned(v);
        sh  = TABLE_SHIFT - frac_bits;
        mag = (mag + (64'd1 << (sh - 1))) >> sh;
        return (v < 0) ? -$signed(mag) : $signed(mag);
    endfunction

endpackage

@@ rtl/core/zsc_fir_ctrl.sv @@
// ----------------------------------------------------------------------------
// ZOH sinc compensation FIR controller
// Sequences the load, the 17 coefficient-pair steps, the pipeline drain and
// the hand-over of each result to the output register.
// ----------------------------------------------------------------------------
module zsc_fir_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output zsc_fir_pkg::t_dp_cmd o_cmd
);

    localparam int DRAIN_CYCLES = 3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_FINISH
    } t_state;

    t_state                             r_state;
    logic [zsc_fir_pkg::PAIR_IDX_W-1:0] r_cnt;
    logic                               r_out_valid;
    logic                               w_out_free;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd        = '0;
        o_cmd.load   = (r_state == ST_IDLE) && i_in_valid;
        o_cmd.rd     = (r_state == ST_RUN);
        o_cmd.center = (r_state == ST_RUN) &&
                       (r_cnt == zsc_fir_pkg::PAIR_IDX_W'(zsc_fir_pkg::HALF_TAPS));
        o_cmd.idx    = r_cnt;
        o_cmd.finish = (r_state == ST_FINISH) && w_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= ST_RUN;
                        r_cnt   <= '0;
                    end
                end
                ST_RUN: begin
                    if (r_cnt == zsc_fir_pkg::PAIR_IDX_W'(zsc_fir_pkg::HALF_TAPS)) begin
                        r_state <= ST_DRAIN;
                        r_cnt   <= '0;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_DRAIN: begin
                    if (r_cnt == zsc_fir_pkg::PAIR_IDX_W'(DRAIN_CYCLES - 1)) begin
                        r_state <= ST_FINISH;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_FINISH: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase

            if (o_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

@@ rtl/core/zsc_fir_dp.sv @@
// ----------------------------------------------------------------------------
// ZOH sinc compensation FIR datapath
// Circular delay-line memory with two read ports, pre-adder, one shared
// multiplier, accumulator, and rounding and saturation into the output register.
// ----------------------------------------------------------------------------
module zsc_fir_dp #(
    parameter int COEF_FRAC_BITS = 22
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  zsc_fir_pkg::t_dp_cmd   i_cmd,
    input  zsc_fir_pkg::t_in_item  i_in_data,
    output zsc_fir_pkg::t_out_item o_out_data
);

    localparam int SB     = zsc_fir_pkg::SAMPLE_BITS;
    localparam int AW     = zsc_fir_pkg::TAP_IDX_W;
    localparam int PW     = zsc_fir_pkg::PAIR_IDX_W;
    localparam int PRE_W  = SB + 1;
    localparam int COEF_W = COEF_FRAC_BITS + 2;
    localparam int PROD_W = PRE_W + COEF_W;
    localparam int ACC_W  = PROD_W + 5;
    localparam logic [AW-1:0] LAST_ADDR = AW'(zsc_fir_pkg::TAP_COUNT - 1);
    localparam logic signed [ACC_W-1:0] RND_HALF =
        {{(ACC_W-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] SAT_MAX =
        {{(ACC_W-SB+1){1'b0}}, {(SB-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_MIN = ~SAT_MAX;

    // Delay-line memory; an entry never written since reset reads as zero.
    logic signed [SB-1:0] r_mem [zsc_fir_pkg::TAP_COUNT];
    logic [zsc_fir_pkg::TAP_COUNT-1:0] r_vld;

    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_ra;
    logic [AW-1:0] r_rb;
    logic [AW-1:0] w_wp_inc;
    logic          r_last;

    logic signed [SB-1:0] r_da;
    logic signed [SB-1:0] r_db;
    logic                 r_va;
    logic                 r_vb;
    logic                 r_s1_v;
    logic                 r_s1_center;
    logic [PW-1:0]        r_s1_idx;

    logic signed [SB-1:0]     w_sa;
    logic signed [SB-1:0]     w_sb;
    logic signed [PRE_W-1:0]  r_pre;
    logic signed [COEF_W-1:0] r_coef;
    logic                     r_s2_v;

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_s3_v;

    logic signed [ACC_W-1:0] r_acc;
    logic signed [ACC_W-1:0] w_rnd;
    logic signed [SB-1:0]    w_sat;

    zsc_fir_pkg::t_out_item r_out;

    assign w_wp_inc = (r_wp == LAST_ADDR) ? '0 : r_wp + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mem[w_wp_inc] <= i_in_data.sample_in;
        end
        if (i_cmd.rd) begin
            r_da <= r_mem[r_ra];
            r_db <= r_mem[r_rb];
        end
    end

    // Read addresses walk inwards from both ends of the window: one towards older
    // samples from the newest, the other towards newer ones from the oldest.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_wp        <= '0;
            r_ra        <= '0;
            r_rb        <= '0;
            r_va        <= 1'b0;
            r_vb        <= 1'b0;
            r_s1_v      <= 1'b0;
            r_s2_v      <= 1'b0;
            r_s3_v      <= 1'b0;
        end else begin
            r_s1_v <= i_cmd.rd;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            if (i_cmd.load) begin
                r_vld[w_wp_inc] <= 1'b1;
                r_wp            <= w_wp_inc;
                r_ra            <= w_wp_inc;
                r_rb            <= (w_wp_inc == LAST_ADDR) ? '0 : w_wp_inc + 1'b1;
            end else if (i_cmd.rd) begin
                r_ra <= (r_ra == '0) ? LAST_ADDR : r_ra - 1'b1;
                r_rb <= (r_rb == LAST_ADDR) ? '0 : r_rb + 1'b1;
                r_va <= r_vld[r_ra];
                r_vb <= r_vld[r_rb];
            end
        end
    end

    // The centre tap has no partner, so the second operand is dropped there.
    assign w_sa = r_va ? r_da : '0;
    assign w_sb = (r_vb && !r_s1_center) ? r_db : '0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_last <= i_in_data.block_last_in;
        end
        if (i_cmd.rd) begin
            r_s1_center <= i_cmd.center;
            r_s1_idx    <= i_cmd.idx;
        end
        r_pre  <= {w_sa[SB-1], w_sa} + {w_sb[SB-1], w_sb};
        r_coef <= COEF_W'(zsc_fir_pkg::coef_round(r_s1_idx, COEF_FRAC_BITS));
        r_prod <= r_pre * r_coef;
        if (i_cmd.load) begin
            r_acc <= '0;
        end else if (r_s3_v) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    always_comb begin
        w_rnd = (r_acc + RND_HALF) >>> COEF_FRAC_BITS;
        if (w_rnd > SAT_MAX) begin
            w_sat = SAT_MAX[SB-1:0];
        end else if (w_rnd < SAT_MIN) begin
            w_sat = SAT_MIN[SB-1:0];
        end else begin
            w_sat = w_rnd[SB-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out.sample_out     <= w_sat;
            r_out.block_last_out <= r_last;
        end
    end

    assign o_out_data = r_out;

endmodule

@@ rtl/core/zoh_sinc_compensation_fir.sv @@
// A result reaches the output register once the coefficient steps and the pipeline drain are done.
// Samples are taken one at a time: the input stalls while the single shared multiply-accumulate
// steps through the 17 coefficient steps, the pipeline drains and the result is handed over.
// A new sample is taken while the previous result still waits in the output register.
// Reset: the delay line reads as all zero, the controller is idle and no result is valid.
// ----------------------------------------------------------------------------
// ZOH sinc compensation FIR top level
// 33-tap symmetric inverse-sinc filter for 24-bit PCM with rounding and saturation.
// ----------------------------------------------------------------------------
`include "zoh_sinc_compensation_fir_assert.svh"

module zoh_sinc_compensation_fir #(
    parameter int COEF_FRAC_BITS = 22
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  zsc_fir_pkg::t_in_item  i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output zsc_fir_pkg::t_out_item o_out_data
);

    zsc_fir_pkg::t_dp_cmd w_cmd;

    zsc_fir_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd)
    );

    zsc_fir_dp #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_in_data  (i_in_data),
        .o_out_data (o_out_data)
    );

    // A request taken in must keep the input side busy while it is filtered.
    `ZSC_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    // Coefficient steps only run while no new request can be taken.
    `ZSC_ASSERT_IMP(a_step_while_busy, i_clk, i_rst_n, w_cmd.rd, o_in_stall && !w_cmd.load)
    // A result may only overwrite the output register once the old one is gone.
    `ZSC_ASSERT_IMP(a_finish_free, i_clk, i_rst_n, w_cmd.finish, !o_out_valid || !i_out_stall)

endmodule
